@@ rtl/team_message_deframer_macros.svh @@
// Assertion macros for the team message deframer.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef TEAM_MESSAGE_DEFRAMER_MACROS_SVH
`define TEAM_MESSAGE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define TMD_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmd assertion failed");

// next-cycle implication
`define TMD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmd assertion failed");

`endif

@@ rtl/tmd_pkg.sv @@
// Shared types, codes and helpers of the team message deframer.
// No dependencies.
package tmd_pkg;

	localparam int HEADER_BYTES = 4;

	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HEADER_ENABLE    = 2'd0,
		REG_HEADER_WORD      = 2'd1,
		REG_EXPECTED_VERSION = 2'd2
	} reg_idx_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_STAMP   = 3'd0,
		KIND_CTRL    = 3'd1,
		KIND_SYNC    = 3'd2,
		KIND_PAYLOAD = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic {
		ERR_HEADER  = 1'b0,
		ERR_VERSION = 1'b1
	} err_t;

	typedef enum logic [2:0] {
		PH_WAIT    = 3'd0,
		PH_HDR     = 3'd1,
		PH_VER     = 3'd2,
		PH_MAGIC   = 3'd3,
		PH_STAMP   = 3'd4,
		PH_CTRL    = 3'd5,
		PH_SYNC    = 3'd6,
		PH_PAYLOAD = 3'd7
	} phase_t;

	typedef struct packed {
		logic        header_enable;
		logic [31:0] header_word;
		logic [7:0]  expected_version;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] value;
		logic [31:0] receipt_time;
		logic [3:0]  receiver;
		logic        request_flag;
		logic [7:0]  receiver_mask;
		logic [22:0] payload_size;
		logic [7:0]  magic;
		err_t        error_code;
		logic        end_of_message;
	} res_t;

	// receiver 1 sits in mask bit 7; zero when no bit is set
	function automatic logic [3:0] lowest_receiver(input logic [7:0] mask);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 0; i < 8; i++) begin
			if (r == 4'd0 && mask[7-i])
				r = 4'(i + 1);
		end
		return r;
	endfunction

endpackage

@@ rtl/tmd_rx_if.sv @@
// Byte input channel of the deframer: valid/ready plus one message byte.
// No dependencies.
interface tmd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source(output valid, output data_byte, output first_byte, input ready);
	modport sink(input valid, input data_byte, input first_byte, output ready);
endinterface

@@ rtl/tmd_res_if.sv @@
// Result channel of the deframer: valid/ready plus the decoded fields.
// Depends on tmd_pkg.
interface tmd_res_if import tmd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [31:0]       value;
	logic [31:0]       receipt_time;
	logic [3:0]        receiver;
	logic              request_flag;
	logic [7:0]        receiver_mask;
	logic [22:0]       payload_size;
	logic [7:0]        magic;
	logic              error_code;
	logic              end_of_message;

	modport source(output valid, output kind, output value, output receipt_time,
		output receiver, output request_flag, output receiver_mask,
		output payload_size, output magic, output error_code,
		output end_of_message, input ready);
	modport sink(input valid, input kind, input value, input receipt_time,
		input receiver, input request_flag, input receiver_mask,
		input payload_size, input magic, input error_code,
		input end_of_message, output ready);
endinterface

@@ rtl/tmd_cfg_regs.sv @@
// Configuration registers of the deframer, written through a plain write port.
// Depends on tmd_pkg.
module tmd_cfg_regs import tmd_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  we,
	input  logic [CFG_IDX_W-1:0]  index,
	input  logic [CFG_DATA_W-1:0] data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_enable    <= 1'b1;
			cfg_q.header_word      <= 32'd0;
			cfg_q.expected_version <= 8'd13;
		end else if (we) begin
			case (index)
				REG_HEADER_ENABLE:    cfg_q.header_enable    <= data[0];
				REG_HEADER_WORD:      cfg_q.header_word      <= data[31:0];
				REG_EXPECTED_VERSION: cfg_q.expected_version <= data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/tmd_parser.sv @@
// Input register and parse state machine: at most one result per byte; one byte per
// cycle while no result is held back. Depends on tmd_pkg and tmd_rx_if.
module tmd_parser import tmd_pkg::*; #(
	parameter int HEADER_BYTES = tmd_pkg::HEADER_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	tmd_rx_if.sink      rx,
	output logic        res_valid,
	output res_t        res,
	input  logic        res_ready
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       first_s1;

	phase_t      phase_q, phase_n;
	logic [2:0]  count_q, count_n;
	logic [31:0] asm_q, asm_n;
	logic [31:0] stamp_q, stamp_n;
	logic [7:0]  pend_q, pend_n;
	logic [3:0]  rcv_q, rcv_n;
	logic [22:0] left_q, left_n;
	logic [7:0]  magic_q, magic_n;

	logic hit;
	logic advance;

	assign advance  = valid_s1 && (!hit || res_ready);
	assign rx.ready = !valid_s1 || advance;
	assign res_valid = valid_s1 && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1  <= rx.data_byte;
			first_s1 <= rx.first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			count_q <= 3'd0;
			asm_q   <= 32'd0;
			stamp_q <= 32'd0;
			pend_q  <= 8'd0;
			rcv_q   <= 4'd0;
			left_q  <= 23'd0;
			magic_q <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_n;
			count_q <= count_n;
			asm_q   <= asm_n;
			stamp_q <= stamp_n;
			pend_q  <= pend_n;
			rcv_q   <= rcv_n;
			left_q  <= left_n;
			magic_q <= magic_n;
		end
	end

	always_comb begin
		logic [31:0] merged;
		logic [2:0]  cnt_inc;
		logic [7:0]  want;
		logic        last;
		logic [11:0] diff;

		phase_n = phase_q;
		count_n = count_q;
		asm_n   = asm_q;
		stamp_n = stamp_q;
		pend_n  = pend_q;
		rcv_n   = rcv_q;
		left_n  = left_q;
		magic_n = magic_q;
		hit     = 1'b0;
		last    = 1'b0;
		res     = '0;
		res.kind       = KIND_STAMP;
		res.error_code = ERR_HEADER;

		if (first_s1) begin
			phase_n = cfg.header_enable ? PH_HDR : PH_STAMP;
			count_n = 3'd0;
			asm_n   = 32'd0;
			pend_n  = 8'd0;
			rcv_n   = 4'd0;
			left_n  = 23'd0;
			magic_n = 8'd0;
		end

		merged  = asm_n | ({24'd0, byte_s1} << {count_n[1:0], 3'b000});
		cnt_inc = count_n + 3'd1;
		want    = cfg.header_word[{count_n[1:0], 3'b000} +: 8];
		diff    = {asm_n[31:28], byte_s1};

		case (phase_n)
			PH_HDR: begin
				if (byte_s1 != want) begin
					hit = 1'b1;
					last = 1'b1;
					res.kind = KIND_ERROR;
					res.error_code = ERR_HEADER;
				end else if (cnt_inc >= 3'(HEADER_BYTES)) begin
					count_n = 3'd0;
					phase_n = PH_VER;
				end else begin
					count_n = cnt_inc;
				end
			end
			PH_VER: begin
				if (byte_s1 != cfg.expected_version) begin
					hit = 1'b1;
					last = 1'b1;
					res.kind = KIND_ERROR;
					res.error_code = ERR_VERSION;
				end else begin
					phase_n = PH_MAGIC;
				end
			end
			PH_MAGIC: begin
				magic_n = byte_s1;
				phase_n = PH_STAMP;
				count_n = 3'd0;
				asm_n   = 32'd0;
			end
			PH_STAMP: begin
				if (cnt_inc < 3'd4) begin
					asm_n   = merged;
					count_n = cnt_inc;
				end else begin
					stamp_n = merged;
					count_n = 3'd0;
					asm_n   = 32'd0;
					phase_n = PH_CTRL;
					hit = 1'b1;
					res.kind  = KIND_STAMP;
					res.value = merged;
				end
			end
			PH_CTRL: begin
				if (cnt_inc < 3'd4) begin
					asm_n   = merged;
					count_n = cnt_inc;
				end else begin
					left_n = merged[31:9];
					pend_n = merged[7:0];
					hit = 1'b1;
					res.kind          = KIND_CTRL;
					res.request_flag  = merged[8];
					res.receiver_mask = merged[7:0];
					res.payload_size  = merged[31:9];
				end
			end
			PH_SYNC: begin
				if (count_n < 3'd4) begin
					asm_n   = merged;
					count_n = cnt_inc;
				end else begin
					if (rcv_n >= 4'd1 && rcv_n <= 4'd8)
						pend_n[3'(4'd8 - rcv_n)] = 1'b0;
					hit = 1'b1;
					res.kind         = KIND_SYNC;
					res.value        = {4'd0, asm_n[27:0]};
					res.receipt_time = stamp_n - {20'd0, diff};
					res.receiver     = rcv_n;
				end
			end
			PH_PAYLOAD: begin
				left_n = left_n - 23'd1;
				last = (left_n == 23'd0);
				hit = 1'b1;
				res.kind  = KIND_PAYLOAD;
				res.value = {24'd0, byte_s1};
			end
			default: ;
		endcase

		// control word and sync entry pick what follows
		if (hit && (res.kind == KIND_CTRL || res.kind == KIND_SYNC)) begin
			count_n = 3'd0;
			asm_n   = 32'd0;
			if (pend_n != 8'd0) begin
				rcv_n   = lowest_receiver(pend_n);
				phase_n = PH_SYNC;
			end else begin
				rcv_n = 4'd0;
				if (left_n != 23'd0)
					phase_n = PH_PAYLOAD;
				else
					last = 1'b1;
			end
		end

		if (last)
			phase_n = PH_WAIT;
		res.magic          = magic_n;
		res.end_of_message = last;
	end

endmodule

@@ rtl/tmd_out_reg.sv @@
// Result register between the parser and the result channel.
// Depends on tmd_pkg and tmd_res_if.
module tmd_out_reg import tmd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   up_valid,
	input  res_t   up_res,
	output logic   up_ready,
	tmd_res_if.source res
);

	logic vld_q;
	res_t res_q;

	assign up_ready = !vld_q || res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready)
			res_q <= up_res;
	end

	assign res.valid          = vld_q;
	assign res.kind           = res_q.kind;
	assign res.value          = res_q.value;
	assign res.receipt_time   = res_q.receipt_time;
	assign res.receiver       = res_q.receiver;
	assign res.request_flag   = res_q.request_flag;
	assign res.receiver_mask  = res_q.receiver_mask;
	assign res.payload_size   = res_q.payload_size;
	assign res.magic          = res_q.magic;
	assign res.error_code     = res_q.error_code;
	assign res.end_of_message = res_q.end_of_message;

endmodule

@@ rtl/team_message_deframer.sv @@
// Team message deframer top level: config registers, parser, result register.
// Depends on tmd_pkg, tmd_rx_if, tmd_res_if, tmd_cfg_regs, tmd_parser, tmd_out_reg and the macros header.
//
//  channel | dir | request carries
//  rx      | in  | data_byte, first_byte
//  res     | out | kind, value, receipt_time, receiver, request_flag,
//          |     | receiver_mask, payload_size, magic, error_code, end_of_message
//  cfg     | in  | cfg_we, cfg_index, cfg_data (write only)
//
// One byte per cycle sustained while the result channel is ready.
// Input register, then one parse step, then the result register.
// A stalled result blocks the parser only when that byte yields a result.
// Reset puts the parser in wait-for-first-byte and the registers to defaults.
`include "team_message_deframer_macros.svh"

module team_message_deframer import tmd_pkg::*; #(
	parameter int HEADER_BYTES = tmd_pkg::HEADER_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	tmd_rx_if.sink                rx,
	tmd_res_if.source             res,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg;
	logic par_valid;
	res_t par_res;
	logic par_ready;

	tmd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tmd_parser #(
		.HEADER_BYTES (HEADER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.rx        (rx),
		.res_valid (par_valid),
		.res       (par_res),
		.res_ready (par_ready)
	);

	tmd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (par_valid),
		.up_res   (par_res),
		.up_ready (par_ready),
		.res      (res)
	);

	`TMD_ASSERT_SAME(a_error_ends, res.valid && res.kind == KIND_ERROR, res.end_of_message)
	`TMD_ASSERT_SAME(a_sync_rcv, res.valid && res.kind == KIND_SYNC, res.receiver >= 4'd1 && res.receiver <= 4'd8)
	`TMD_ASSERT_SAME(a_empty_ctrl, res.valid && res.kind == KIND_CTRL && res.receiver_mask == 8'd0 && res.payload_size == 23'd0, res.end_of_message)
	`TMD_ASSERT_NEXT(a_held_result, par_valid && par_ready, res.valid)

endmodule

@@ tb/sv/tb_team_message_deframer.sv @@
// Testbench of the team message deframer: byte requests in, decoded field requests out,
// each result checked field by field against an in-bench parser of the message format.
// Depends on tmd_pkg, tmd_rx_if, tmd_res_if and team_message_deframer.
module tb_team_message_deframer;
	timeunit 1ns;
	timeprecision 1ps;

	import tmd_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
	} rx_item_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tmd_rx_if  byte_in();
	tmd_res_if field_out();

	team_message_deframer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (byte_in),
		.res       (field_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// register copies
	logic        cfg_header_on;
	logic [31:0] cfg_header_word;
	logic [7:0]  cfg_version;

	// parser state
	phase_t      ph;
	logic [2:0]  cnt;
	logic [31:0] acc;
	logic [31:0] stamp;
	logic [7:0]  pend;
	logic [3:0]  nxt;
	logic [22:0] left;
	logic [7:0]  magic_held;

	rx_item_t outgoing_bytes[$];
	res_t     awaited[$];
	rx_item_t head;
	logic [8:0] opening_seq [26];

	int  items_queued = 0;
	int  results_seen = 0;
	int  field_errors = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  src_idle_pct = 0;
	int  snk_idle_pct = 0;
	logic hold_results = 1'b0;

	function automatic res_t fresh_result(input kind_t k, input logic last);
		res_t r;
		r = '0;
		r.kind = k;
		r.magic = magic_held;
		r.end_of_message = last;
		if (last)
			ph = PH_WAIT;
		return r;
	endfunction

	// after the control word or a sync entry; 1 when the message is complete
	function automatic logic pick_next_part();
		cnt = '0;
		acc = '0;
		nxt = '0;
		if (pend != 0) begin
			for (int k = 7; k >= 0; k--)
				if (pend[k] && nxt == 0)
					nxt = 4'(8 - k);
			ph = PH_SYNC;
			return 1'b0;
		end
		if (left != 0) begin
			ph = PH_PAYLOAD;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic deframe_byte(input logic [7:0] b, input logic first);
		res_t        r;
		logic [31:0] w;
		logic [11:0] diff;
		logic [3:0]  rcv;
		logic        last;
		if (first) begin
			if (cfg_header_on)
				ph = PH_HDR;
			else
				ph = PH_STAMP;
			cnt = '0;
			acc = '0;
			pend = '0;
			nxt = '0;
			left = '0;
			magic_held = '0;
		end
		case (ph)
			PH_HDR: begin
				if (b != cfg_header_word[8*cnt[1:0] +: 8]) begin
					r = fresh_result(KIND_ERROR, 1'b1);
					r.error_code = ERR_HEADER;
					awaited.push_back(r);
				end else begin
					cnt++;
					if (cnt >= HEADER_BYTES) begin
						cnt = '0;
						ph = PH_VER;
					end
				end
			end
			PH_VER: begin
				if (b != cfg_version) begin
					r = fresh_result(KIND_ERROR, 1'b1);
					r.error_code = ERR_VERSION;
					awaited.push_back(r);
				end else
					ph = PH_MAGIC;
			end
			PH_MAGIC: begin
				magic_held = b;
				ph = PH_STAMP;
				cnt = '0;
				acc = '0;
			end
			PH_STAMP: begin
				acc |= 32'(b) << (8 * cnt[1:0]);
				cnt++;
				if (cnt == 4) begin
					stamp = acc;
					cnt = '0;
					acc = '0;
					ph = PH_CTRL;
					r = fresh_result(KIND_STAMP, 1'b0);
					r.value = stamp;
					awaited.push_back(r);
				end
			end
			PH_CTRL: begin
				acc |= 32'(b) << (8 * cnt[1:0]);
				cnt++;
				if (cnt == 4) begin
					w = acc;
					left = w[31:9];
					pend = w[7:0];
					last = pick_next_part();
					r = fresh_result(KIND_CTRL, last);
					r.request_flag = w[8];
					r.receiver_mask = w[7:0];
					r.payload_size = w[31:9];
					awaited.push_back(r);
				end
			end
			PH_SYNC: begin
				if (cnt < 4) begin
					acc |= 32'(b) << (8 * cnt[1:0]);
					cnt++;
				end else begin
					w = acc;
					diff = {w[31:28], b};
					rcv = nxt;
					if (rcv >= 1 && rcv <= 8)
						pend[8 - rcv] = 1'b0;
					last = pick_next_part();
					r = fresh_result(KIND_SYNC, last);
					r.value = {4'h0, w[27:0]};
					r.receipt_time = stamp - {20'h0, diff};
					r.receiver = rcv;
					awaited.push_back(r);
				end
			end
			PH_PAYLOAD: begin
				left = left - 23'd1;
				r = fresh_result(KIND_PAYLOAD, left == 0);
				r.value = {24'h0, b};
				awaited.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			field_errors++;
			if (field_errors <= 10)
				$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
		end
	endtask

	task automatic check_result();
		res_t want;
		if (awaited.size() == 0) begin
			field_errors++;
			if (field_errors <= 10)
				$display("%0t: result of kind %0d with nothing awaited", $time,
					field_out.kind);
		end else begin
			want = awaited.pop_front();
			compare_field("kind", want.kind, field_out.kind);
			compare_field("value", want.value, field_out.value);
			compare_field("receipt_time", want.receipt_time, field_out.receipt_time);
			compare_field("receiver", want.receiver, field_out.receiver);
			compare_field("request_flag", want.request_flag, field_out.request_flag);
			compare_field("receiver_mask", want.receiver_mask, field_out.receiver_mask);
			compare_field("payload_size", want.payload_size, field_out.payload_size);
			compare_field("magic", want.magic, field_out.magic);
			compare_field("error_code", want.error_code, field_out.error_code);
			compare_field("end_of_message", want.end_of_message,
				field_out.end_of_message);
		end
	endtask

	// driver: one request per byte, random gaps between requests
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_in.valid <= 1'b0;
			byte_in.data_byte <= '0;
			byte_in.first_byte <= 1'b0;
			src_gap = 0;
		end else begin
			if (byte_in.valid && byte_in.ready)
				deframe_byte(byte_in.data_byte, byte_in.first_byte);
			if (!byte_in.valid || byte_in.ready) begin
				if (src_gap > 0) begin
					src_gap--;
					byte_in.valid <= 1'b0;
				end else if (outgoing_bytes.size() > 0) begin
					head = outgoing_bytes.pop_front();
					byte_in.valid <= 1'b1;
					byte_in.data_byte <= head.data;
					byte_in.first_byte <= head.first;
					if ($urandom_range(0, 99) < src_idle_pct)
						src_gap = $urandom_range(1, 13);
				end else
					byte_in.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_out.ready <= 1'b0;
			snk_gap = 0;
		end else begin
			if (field_out.valid && field_out.ready) begin
				check_result();
				results_seen++;
			end
			if (hold_results)
				field_out.ready <= 1'b0;
			else if (snk_gap > 0) begin
				snk_gap--;
				field_out.ready <= 1'b0;
			end else begin
				field_out.ready <= 1'b1;
				if ($urandom_range(0, 99) < snk_idle_pct)
					snk_gap = $urandom_range(1, 13);
			end
		end
	end

	// long hold-off on results while bytes keep coming, so the input stalls
	initial begin
		do
			@(posedge clk);
		while (!(results_seen >= 80 && outgoing_bytes.size() > 60));
		hold_results <= 1'b1;
		repeat (400) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		case (idx)
			REG_HEADER_ENABLE:    cfg_header_on = d[0];
			REG_HEADER_WORD:      cfg_header_word = d;
			REG_EXPECTED_VERSION: cfg_version = d[7:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_until_drained();
		do
			@(negedge clk);
		while (outgoing_bytes.size() != 0 || byte_in.valid || awaited.size() != 0);
	endtask

	// keep < 0 sends the whole message; spoil 1 breaks a header byte, 2 the version
	task automatic queue_message(input logic [7:0] mask, input logic [22:0] size,
		input int keep, input int spoil);
		logic [7:0]  msg[$];
		logic [31:0] stamp_v;
		logic [31:0] ctrl;
		int          at;
		rx_item_t    it;
		if (cfg_header_on) begin
			for (int i = 0; i < HEADER_BYTES; i++)
				msg.push_back(cfg_header_word[8*i +: 8]);
			msg.push_back(cfg_version);
			msg.push_back(8'($urandom));
		end
		case ($urandom_range(0, 3))
			0: stamp_v = '0;
			1: stamp_v = '1;
			default: stamp_v = $urandom;
		endcase
		ctrl = {size, 1'($urandom), mask};
		for (int i = 0; i < 4; i++)
			msg.push_back(stamp_v[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			msg.push_back(ctrl[8*i +: 8]);
		for (int i = 0; i < 5 * $countones(mask); i++)
			msg.push_back(8'($urandom));
		for (int i = 0; i < size && i < 12; i++)
			msg.push_back(8'($urandom));
		if (spoil != 0) begin
			at = (spoil == 1) ? $urandom_range(0, HEADER_BYTES - 1) : HEADER_BYTES;
			msg[at] = msg[at] ^ 8'($urandom_range(1, 255));
			keep = at + 3;
		end
		for (int i = 0; i < msg.size() && (keep < 0 || i < keep); i++) begin
			it.data = msg[i];
			it.first = (i == 0);
			outgoing_bytes.push_back(it);
			items_queued++;
		end
	endtask

	task automatic queue_random_message();
		logic [7:0]  mask;
		logic [22:0] size;
		int          pick;
		rx_item_t    it;
		pick = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: mask = 8'h00;
			1: mask = 8'h80 >> $urandom_range(0, 7);
			default: mask = 8'($urandom);
		endcase
		size = ($urandom_range(0, 3) == 0) ? 23'd0 : 23'($urandom_range(1, 6));
		if (pick < 55)
			queue_message(mask, size, -1, 0);
		else if (pick < 67)
			queue_message(mask, size, $urandom_range(1, 20), 0);
		else if (pick < 77 && cfg_header_on)
			queue_message(mask, size, -1, $urandom_range(1, 2));
		else if (pick < 87)
			queue_message(mask, 23'($urandom), -1, 0);
		else begin
			// stray bytes, ignored unless a message is still open
			repeat ($urandom_range(1, 4)) begin
				it.data = 8'($urandom);
				it.first = 1'b0;
				outgoing_bytes.push_back(it);
			end
			queue_message(mask, size, -1, 0);
		end
	endtask

	initial begin
		rx_item_t it;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		byte_in.valid = 1'b0;
		byte_in.data_byte = '0;
		byte_in.first_byte = 1'b0;
		field_out.ready = 1'b0;
		cfg_header_on = 1'b1;
		cfg_header_word = '0;
		cfg_version = 8'd13;
		ph = PH_WAIT;
		cnt = '0;
		acc = '0;
		stamp = '0;
		pend = '0;
		nxt = '0;
		left = '0;
		magic_held = '0;
		// stray bytes; empty-tail message; header error then an ignored byte;
		// restart mid-header; version error
		opening_seq = '{9'h000, 9'h0FF,
			9'h100, 9'h000, 9'h000, 9'h000, 9'h00D, 9'h0FF, 9'h0FF, 9'h0FF,
			9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000, 9'h000,
			9'h1FF, 9'h00D,
			9'h100, 9'h000, 9'h000,
			9'h100, 9'h000, 9'h000, 9'h000, 9'h0FF};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		for (int p = 0; p < 6; p++) begin
			if (p > 0) begin
				wait_until_drained();
				repeat (6) @(posedge clk);
				case (p)
					1: write_reg(REG_HEADER_ENABLE, 32'd0);
					2: begin
						write_reg(REG_HEADER_ENABLE, 32'd1);
						write_reg(REG_HEADER_WORD, 32'hFFFF_FFFF);
						write_reg(REG_EXPECTED_VERSION, 32'hFF);
					end
					3: begin
						write_reg(REG_HEADER_WORD, $urandom);
						write_reg(REG_EXPECTED_VERSION, 32'd0);
					end
					4: begin
						write_reg(REG_HEADER_ENABLE, 32'd0);
						write_reg(REG_HEADER_WORD, $urandom);
						write_reg(REG_EXPECTED_VERSION, $urandom_range(0, 255));
					end
					default: begin
						write_reg(REG_HEADER_ENABLE, 32'd1);
						write_reg(REG_EXPECTED_VERSION, $urandom_range(0, 255));
					end
				endcase
				@(negedge clk);
			end
			src_idle_pct = (p == 5) ? 0 : 5 + 10 * $urandom_range(0, 3);
			snk_idle_pct = (p == 5) ? 0 : 5 + 10 * $urandom_range(0, 3);
			if (p == 0) begin
				for (int i = 0; i < 26; i++) begin
					it.data = opening_seq[i][7:0];
					it.first = opening_seq[i][8];
					outgoing_bytes.push_back(it);
					items_queued++;
				end
			end
			while (items_queued < 175 * (p + 1))
				queue_random_message();
		end
		wait_until_drained();
		repeat (8) @(posedge clk);
		if (field_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tmd_pkg.sv
rtl/tmd_rx_if.sv
rtl/tmd_res_if.sv
rtl/tmd_cfg_regs.sv
rtl/tmd_parser.sv
rtl/tmd_out_reg.sv
rtl/team_message_deframer.sv
tb/sv/tb_team_message_deframer.sv
